FILE: sv/dhlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dhlt_pkg;

    localparam int unsigned TRIG_STAGES = 14;
    localparam int unsigned COMB_STAGES = 2;
    localparam int unsigned PIPE_STAGES = TRIG_STAGES + COMB_STAGES;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 184;

    // Input request, last field in the lowest bits.
    typedef struct packed {
        logic signed [15:0] link_twist;
        logic signed [17:0] link_length;
        logic signed [15:0] joint_angle;
        logic signed [17:0] link_offset;
    } in_t;

    // Sine and cosine of one angle, Q30.
    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } sc_t;

    // Result request, last field in the lowest bits.
    typedef struct packed {
        logic signed [17:0] trans_z;
        logic signed [17:0] trans_y;
        logic signed [17:0] trans_x;
        logic signed [15:0] r22;
        logic signed [15:0] r21;
        logic signed [15:0] r12;
        logic signed [15:0] r11;
        logic signed [15:0] r10;
        logic signed [15:0] r02;
        logic signed [15:0] r01;
        logic signed [15:0] r00;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/dhlt_trig.sv
`timescale 1ns / 1ps
`default_nettype none

module dhlt_trig
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [15:0] angle,
    output dhlt_pkg::sc_t           sc
);

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    localparam logic [17:0] TURN_PER_Q12 = 18'd166886;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;

    // Exact floor division of a 30-bit value by a constant through a reciprocal.
    localparam int unsigned SH72 = 37;
    localparam int unsigned SH42 = 36;
    localparam int unsigned SH20 = 35;
    localparam int unsigned SH6  = 33;
    localparam int unsigned SH56 = 36;
    localparam int unsigned SH30 = 35;
    localparam int unsigned SH12 = 34;
    localparam logic [30:0] M72 = 31'(((64'd1 << SH72) + 64'd71) / 64'd72);
    localparam logic [30:0] M42 = 31'(((64'd1 << SH42) + 64'd41) / 64'd42);
    localparam logic [30:0] M20 = 31'(((64'd1 << SH20) + 64'd19) / 64'd20);
    localparam logic [30:0] M6  = 31'(((64'd1 << SH6) + 64'd5) / 64'd6);
    localparam logic [30:0] M56 = 31'(((64'd1 << SH56) + 64'd55) / 64'd56);
    localparam logic [30:0] M30 = 31'(((64'd1 << SH30) + 64'd29) / 64'd30);
    localparam logic [30:0] M12 = 31'(((64'd1 << SH12) + 64'd11) / 64'd12);

    function automatic logic [30:0] one_minus_div(input logic [29:0] x,
                                                  input logic [30:0] m,
                                                  input int unsigned sh);
        logic [60:0] prod;
        logic [29:0] q;
        prod = {31'd0, x} * {30'd0, m};
        q = 30'(prod >> sh);
        return ONE_Q30 - {1'b0, q};
    endfunction

    function automatic logic [29:0] mul_q30(input logic [29:0] x, input logic [30:0] t);
        logic [60:0] prod;
        prod = {31'd0, x} * {30'd0, t};
        return prod[59:30];
    endfunction

    function automatic logic signed [31:0] clamp_one(input logic signed [31:0] v);
        if (v > 32'sd1073741824)
        begin
            return 32'sd1073741824;
        end
        else if (v < -32'sd1073741824)
        begin
            return -32'sd1073741824;
        end
        else
        begin
            return v;
        end
    endfunction

    logic        [31:0] ph_reg;
    logic signed [62:0] pi_prod_reg;
    quad_t              quad_reg [2:13];
    logic signed [30:0] r_reg [3:11];
    logic signed [61:0] sq_reg;
    logic        [29:0] r2_reg [5:9];
    logic        [30:0] t1s_reg, t2s_reg, t3s_reg, t4s_reg;
    logic        [30:0] t1c_reg, t2c_reg, t3c_reg;
    logic        [29:0] y1s_reg, y2s_reg, y3s_reg;
    logic        [29:0] y1c_reg, y2c_reg, y3c_reg;
    logic        [30:0] c_reg [11:13];
    logic signed [62:0] sp_reg;
    logic signed [30:0] s_reg;
    dhlt_pkg::sc_t      sc_reg;

    logic signed [34:0] turn_prod;
    logic        [31:0] ph_next;
    logic        [2:0]  p_hi;
    quad_t              quad_next;
    logic signed [29:0] rt;
    logic signed [62:0] pi_prod_next;
    logic signed [62:0] r_sum;
    logic signed [30:0] r_next;
    logic signed [61:0] sq_next;
    logic        [29:0] r2_next;
    logic signed [62:0] sp_next;
    logic signed [62:0] s_sum;
    logic signed [30:0] s_next;
    logic        [30:0] c_next;
    logic signed [31:0] s_ext, c_ext;
    dhlt_pkg::sc_t      sc_next;

    always_comb
    begin
        turn_prod    = angle * $signed({1'b0, TURN_PER_Q12});
        ph_next      = turn_prod[31:0];

        // Adding an eighth of a turn centers each quadrant on zero.
        p_hi         = ph_reg[31:29] + 3'd1;
        quad_next    = quad_t'(p_hi[2:1]);
        rt           = $signed(ph_reg[29:0]);
        pi_prod_next = rt * $signed({1'b0, PI_Q30});

        r_sum        = pi_prod_reg + 63'sd1073741824;
        r_next       = $signed(r_sum[61:31]);

        sq_next      = r_reg[3] * r_reg[3];
        r2_next      = sq_reg[59:30];

        sp_next      = r_reg[11] * $signed({1'b0, t4s_reg});
        s_sum        = sp_reg + 63'sd536870912;
        s_next       = $signed(s_sum[60:30]);
        c_next       = ONE_Q30 - {2'b00, y3c_reg[29:1]};

        s_ext        = {s_reg[30], s_reg};
        c_ext        = $signed({1'b0, c_reg[13]});
        case (quad_reg[13])
            QUAD_0:
            begin
                sc_next.sn = s_ext;
                sc_next.cs = c_ext;
            end
            QUAD_90:
            begin
                sc_next.sn = c_ext;
                sc_next.cs = -s_ext;
            end
            QUAD_180:
            begin
                sc_next.sn = -s_ext;
                sc_next.cs = -c_ext;
            end
            default:
            begin
                sc_next.sn = -c_ext;
                sc_next.cs = s_ext;
            end
        endcase
        sc_next.sn = clamp_one(sc_next.sn);
        sc_next.cs = clamp_one(sc_next.cs);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg      <= ph_next;
            pi_prod_reg <= pi_prod_next;
            quad_reg[2] <= quad_next;
            for (int k = 3; k <= 13; k++)
            begin
                quad_reg[k] <= quad_reg[k - 1];
            end
            r_reg[3] <= r_next;
            for (int k = 4; k <= 11; k++)
            begin
                r_reg[k] <= r_reg[k - 1];
            end
            sq_reg    <= sq_next;
            r2_reg[5] <= r2_next;
            for (int k = 6; k <= 9; k++)
            begin
                r2_reg[k] <= r2_reg[k - 1];
            end

            t1s_reg <= one_minus_div(r2_next, M72, SH72);
            t1c_reg <= one_minus_div(r2_next, M56, SH56);
            y1s_reg <= mul_q30(r2_reg[5], t1s_reg);
            y1c_reg <= mul_q30(r2_reg[5], t1c_reg);
            t2s_reg <= one_minus_div(y1s_reg, M42, SH42);
            t2c_reg <= one_minus_div(y1c_reg, M30, SH30);
            y2s_reg <= mul_q30(r2_reg[7], t2s_reg);
            y2c_reg <= mul_q30(r2_reg[7], t2c_reg);
            t3s_reg <= one_minus_div(y2s_reg, M20, SH20);
            t3c_reg <= one_minus_div(y2c_reg, M12, SH12);
            y3s_reg <= mul_q30(r2_reg[9], t3s_reg);
            y3c_reg <= mul_q30(r2_reg[9], t3c_reg);
            t4s_reg <= one_minus_div(y3s_reg, M6, SH6);

            c_reg[11] <= c_next;
            c_reg[12] <= c_reg[11];
            c_reg[13] <= c_reg[12];
            sp_reg    <= sp_next;
            s_reg     <= s_next;
            sc_reg    <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

`default_nettype wire

FILE: sv/dhlt_combine.sv
`timescale 1ns / 1ps
`default_nettype none

module dhlt_combine
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire dhlt_pkg::sc_t      theta,
    input  wire dhlt_pkg::sc_t      alpha,
    input  wire logic signed [17:0] link_length,
    input  wire logic signed [17:0] link_offset,
    output dhlt_pkg::res_t          res
);

    function automatic logic signed [15:0] sat_q14(input logic signed [17:0] v);
        if (v > 18'sd16384)
        begin
            return 16'sd16384;
        end
        else if (v < -18'sd16384)
        begin
            return -16'sd16384;
        end
        else
        begin
            return $signed(v[15:0]);
        end
    endfunction

    function automatic logic signed [15:0] q14_single(input logic signed [31:0] v);
        logic signed [32:0] sum;
        sum = {v[31], v} + 33'sd32768;
        return sat_q14($signed({sum[32], sum[32:16]}));
    endfunction

    // The sign is applied before rounding: -p + half equals ~p + half + 1.
    function automatic logic signed [15:0] q14_prod(input logic signed [63:0] p,
                                                    input logic neg);
        logic signed [63:0] sum;
        if (neg)
        begin
            sum = ~p + 64'sd35184372088833;
        end
        else
        begin
            sum = p + 64'sd35184372088832;
        end
        return sat_q14($signed(sum[63:46]));
    endfunction

    function automatic logic signed [17:0] q15_trans(input logic signed [49:0] p);
        logic signed [49:0] sum;
        logic signed [19:0] q;
        sum = p + 50'sd536870912;
        q = $signed(sum[49:30]);
        if (q > 20'sd131071)
        begin
            return 18'sd131071;
        end
        else if (q < -20'sd131072)
        begin
            return -18'sd131072;
        end
        else
        begin
            return $signed(q[17:0]);
        end
    endfunction

    logic signed [63:0] p_sc_reg, p_ss_reg, p_cc_reg, p_cs_reg;
    logic signed [49:0] tx_reg, ty_reg;
    logic signed [15:0] r00_reg, r10_reg, r21_reg, r22_reg;
    logic signed [17:0] d_reg;
    dhlt_pkg::res_t     res_reg;

    logic signed [63:0] p_sc_next, p_ss_next, p_cc_next, p_cs_next;
    logic signed [49:0] tx_next, ty_next;
    dhlt_pkg::res_t     res_next;

    always_comb
    begin
        p_sc_next = theta.sn * alpha.cs;
        p_ss_next = theta.sn * alpha.sn;
        p_cc_next = theta.cs * alpha.cs;
        p_cs_next = theta.cs * alpha.sn;
        tx_next   = link_length * theta.cs;
        ty_next   = link_length * theta.sn;

        res_next.r00     = r00_reg;
        res_next.r01     = q14_prod(p_sc_reg, 1'b1);
        res_next.r02     = q14_prod(p_ss_reg, 1'b0);
        res_next.r10     = r10_reg;
        res_next.r11     = q14_prod(p_cc_reg, 1'b0);
        res_next.r12     = q14_prod(p_cs_reg, 1'b1);
        res_next.r21     = r21_reg;
        res_next.r22     = r22_reg;
        res_next.trans_x = q15_trans(tx_reg);
        res_next.trans_y = q15_trans(ty_reg);
        res_next.trans_z = d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sc_reg <= p_sc_next;
            p_ss_reg <= p_ss_next;
            p_cc_reg <= p_cc_next;
            p_cs_reg <= p_cs_next;
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            r00_reg  <= q14_single(theta.cs);
            r10_reg  <= q14_single(theta.sn);
            r21_reg  <= q14_single(alpha.sn);
            r22_reg  <= q14_single(alpha.cs);
            d_reg    <= link_offset;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: sv/dh_link_transform_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Denavit-Hartenberg link transform, one link per request.
// The input stream carries offset d, joint angle theta, length a and twist
// alpha; the output stream carries eight rotation entries in Q1.14 and the
// translation (a cos theta, a sin theta, d) in Q2.15.
// A request is taken on every cycle with tvalid and tready high, and a
// new link may enter in every cycle while s_axis_tready is high.
// From the input handshake to tvalid on the output:
// 14 stages compute sine and cosine of both angles in parallel (quadrant
// split, angle scaling, then the Horner steps, each one multiplier deep),
// 2 stages form the products and the rounding, and one output register.
// The output register is backed by a one-entry skid buffer. When the
// receiver stalls, results keep landing until the skid buffer fills; then
// s_axis_tready falls and the whole pipeline holds without losing or
// repeating a request. Reset clears every valid bit, so no result is shown
// after reset until a new request has passed through.

module dh_link_transform_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // link_offset[17:0], joint_angle[33:18], link_length[51:34],
    // link_twist[67:52], zero fill
    input  wire logic [dhlt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r21, r22 (16 bits each from bit 0),
    // trans_x[145:128], trans_y[163:146], trans_z[181:164], zero fill
    output      logic [dhlt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int unsigned LAST = dhlt_pkg::PIPE_STAGES - 1;

    dhlt_pkg::in_t      in_item;
    logic               en;
    logic               take;

    logic [dhlt_pkg::PIPE_STAGES-1:0] vld_reg;
    logic signed [17:0] len_reg [0:dhlt_pkg::TRIG_STAGES-1];
    logic signed [17:0] off_reg [0:dhlt_pkg::TRIG_STAGES-1];

    dhlt_pkg::sc_t      theta_sc;
    dhlt_pkg::sc_t      alpha_sc;
    dhlt_pkg::res_t     res;

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    dhlt_pkg::res_t     out_data_reg, out_data_next;
    dhlt_pkg::res_t     skid_data_reg, skid_data_next;

    assign in_item       = dhlt_pkg::in_t'(s_axis_tdata[$bits(dhlt_pkg::in_t)-1:0]);
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign take          = out_valid_reg && m_axis_tready;

    dhlt_trig u_trig_theta
    (
        .clk   (clk),
        .en    (en),
        .angle (in_item.joint_angle),
        .sc    (theta_sc)
    );

    dhlt_trig u_trig_alpha
    (
        .clk   (clk),
        .en    (en),
        .angle (in_item.link_twist),
        .sc    (alpha_sc)
    );

    dhlt_combine u_combine
    (
        .clk         (clk),
        .en          (en),
        .theta       (theta_sc),
        .alpha       (alpha_sc),
        .link_length (len_reg[dhlt_pkg::TRIG_STAGES-1]),
        .link_offset (off_reg[dhlt_pkg::TRIG_STAGES-1]),
        .res         (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (vld_reg[LAST])
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[dhlt_pkg::PIPE_STAGES-2:0], s_axis_tvalid};
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= in_item.link_length;
            off_reg[0] <= in_item.link_offset;
            for (int k = 1; k < dhlt_pkg::TRIG_STAGES; k++)
            begin
                len_reg[k] <= len_reg[k - 1];
                off_reg[k] <= off_reg[k - 1];
            end
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dhlt_pkg::OUT_TDATA_W - $bits(dhlt_pkg::res_t)){1'b0}},
                            out_data_reg};

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid buffer holds a result while the output register is empty.");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("Skid buffer filled without an output stall.");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_valid_reg && vld_reg[LAST]) |=> out_valid_reg)
        else $error("A finished result was dropped at the output.");

endmodule

`default_nettype wire
